// ===== hw/rtl/mrcc_pkg.sv =====
// Shared types and constants for the mixed-radix coordinate counter.
package mrcc_pkg;

    localparam int COORD_W        = 16;
    localparam int SIZE_W         = 16;
    localparam int DIMS_W         = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_SIZE_REGS  = 4;
    localparam int NUM_OUT_COORDS = 4;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMS_IN_USE = 3'd0,
        CFG_SIZE_DIM0   = 3'd1,
        CFG_SIZE_DIM1   = 3'd2,
        CFG_SIZE_DIM2   = 3'd3,
        CFG_SIZE_DIM3   = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

// ===== hw/rtl/mixed_radix_coordinate_counter_core.sv =====
// Mixed-radix coordinate counter: load from linear index or advance with carries.
// Each item passes IDLE, then per dimension in use SETUP and the bit-serial divider in DIV
// (DW = carry width + 1 quotient bits, 34 at AMOUNT_WIDTH 32), then FINISH; an advance
// dimension with zero carry skips the divider.
// One item in flight: the next item can be accepted in the cycle after the result loads.
// Reset: coordinate digits clear to zero, dims_in_use and all extents to 1.
module mixed_radix_coordinate_counter_core
    import mrcc_pkg::*;
#(
    parameter int MAX_DIMS     = 4,
    parameter int AMOUNT_WIDTH = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [CFG_DATA_W-1:0]                 cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((AMOUNT_WIDTH+7)/8)*8-1:0]     s_tdata,   // amount
    input  logic                                  s_tuser,   // op
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [NUM_OUT_COORDS*COORD_W-1:0]     m_tdata,   // coord0, coord1, coord2, coord3
    output logic                                  m_tuser    // wrapped
);

    // carry never exceeds 2^AW + 8*65535, so one extra bit is enough
    localparam int CW  = (AMOUNT_WIDTH >= 64) ? 64 :
                         ((AMOUNT_WIDTH < 20) ? 21 : AMOUNT_WIDTH + 1);
    localparam int DW  = CW + 1;
    localparam int KW  = $clog2(MAX_DIMS + 1);
    localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    state_t state_reg, state_next;

    logic [DIMS_W-1:0]  dims_reg, dims_next;
    logic [SIZE_W-1:0]  size_reg  [NUM_SIZE_REGS];
    logic [SIZE_W-1:0]  size_next [NUM_SIZE_REGS];
    logic [COORD_W-1:0] digit_reg  [MAX_DIMS];
    logic [COORD_W-1:0] digit_next [MAX_DIMS];

    logic [KW-1:0]      dim_reg, dim_next;
    logic [KW-1:0]      nd_reg, nd_next;
    logic               op_reg, op_next;
    logic [CW-1:0]      carry_reg, carry_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [COORD_W-1:0] out_coord_reg [NUM_OUT_COORDS];
    logic [COORD_W-1:0] out_coord_cur [NUM_OUT_COORDS];
    logic               out_wrap_reg;

    logic [KW-1:0]      nd_cfg;
    logic [31:0]        dim32;
    logic [SIZE_W-1:0]  extent;
    logic [COORD_W-1:0] cur_digit;
    logic [DW-1:0]      dividend;
    logic               setup_end;
    logic               setup_skip;
    logic               in_accept;
    logic               div_start;
    logic               out_load;

    logic               div_done;
    logic [DW-1:0]      div_quot;
    logic [SIZE_W-1:0]  div_rem;

    mrcc_div #(.DW(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (extent),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // ---------------- configuration registers ----------------
    always_comb
    begin
        dims_next = dims_reg;
        for (int i = 0; i < NUM_SIZE_REGS; i++)
            size_next[i] = size_reg[i];
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIMS_IN_USE: dims_next    = cfg_data[DIMS_W-1:0];
                CFG_SIZE_DIM0:   size_next[0] = cfg_data[SIZE_W-1:0];
                CFG_SIZE_DIM1:   size_next[1] = cfg_data[SIZE_W-1:0];
                CFG_SIZE_DIM2:   size_next[2] = cfg_data[SIZE_W-1:0];
                CFG_SIZE_DIM3:   size_next[3] = cfg_data[SIZE_W-1:0];
                default:         dims_next    = dims_reg;
            endcase
        end
    end

    // clamp dimension count to 1..MAX_DIMS
    always_comb
    begin
        if (dims_reg == '0)
            nd_cfg = KW'(1);
        else if (32'(dims_reg) > MAX_DIMS)
            nd_cfg = KW'(MAX_DIMS);
        else
            nd_cfg = KW'(dims_reg);
    end

    // ---------------- per-dimension operands ----------------
    assign dim32     = 32'(dim_reg);
    assign cur_digit = digit_reg[dim_reg[DIW-1:0]];

    always_comb
    begin
        extent = SIZE_W'(1);
        if (dim32 < NUM_SIZE_REGS)
            extent = size_reg[dim32[1:0]];
        if (extent == '0)
            extent = SIZE_W'(1);
    end

    // (carry, plus digit on advance) / extent gives both new digit and outgoing carry
    assign dividend   = DW'(carry_reg) + ((op_reg == OP_ADVANCE) ? DW'(cur_digit) : DW'(0));
    assign setup_end  = (dim_reg == nd_reg);
    assign setup_skip = (op_reg == OP_ADVANCE) && (carry_reg == '0);

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_SETUP;
            ST_SETUP:
                if (setup_end)
                    state_next = ST_FINISH;
                else if (!setup_skip)
                    state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_SETUP;
            ST_FINISH:
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready  = 1'b1;
            ST_SETUP:  div_start = !setup_end && !setup_skip;
            ST_DIV:    div_start = 1'b0;
            ST_FINISH: out_load  = !m_tvalid_reg || m_tready;
            default:   s_tready  = 1'b0;
        endcase
    end

    assign in_accept = s_tvalid && s_tready;

    // ---------------- datapath ----------------
    always_comb
    begin
        dim_next   = dim_reg;
        nd_next    = nd_reg;
        op_next    = op_reg;
        carry_next = carry_reg;
        for (int i = 0; i < MAX_DIMS; i++)
            digit_next[i] = digit_reg[i];

        if (in_accept)
        begin
            op_next    = s_tuser;
            carry_next = CW'(s_tdata[AMOUNT_WIDTH-1:0]);
            nd_next    = nd_cfg;
            dim_next   = '0;
        end
        else if (state_reg == ST_SETUP && !setup_end && setup_skip)
        begin
            dim_next = dim_reg + KW'(1);
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
                if (dim_reg[DIW-1:0] == DIW'(i))
                    digit_next[i] = div_rem;
            carry_next = div_quot[CW-1:0];
            dim_next   = dim_reg + KW'(1);
        end
    end

    // unused dimensions read as zero on the output
    for (genvar g = 0; g < NUM_OUT_COORDS; g++)
    begin : g_out
        if (g < MAX_DIMS)
        begin : g_used
            assign out_coord_cur[g] = (KW'(g) < nd_reg) ? digit_reg[g] : '0;
        end
        else
        begin : g_none
            assign out_coord_cur[g] = '0;
        end
        assign m_tdata[g*COORD_W +: COORD_W] = out_coord_reg[g];
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            dims_reg     <= DIMS_W'(1);
            for (int i = 0; i < NUM_SIZE_REGS; i++)
                size_reg[i] <= SIZE_W'(1);
            for (int i = 0; i < MAX_DIMS; i++)
                digit_reg[i] <= '0;
            dim_reg      <= '0;
            nd_reg       <= KW'(1);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dims_reg     <= dims_next;
            for (int i = 0; i < NUM_SIZE_REGS; i++)
                size_reg[i] <= size_next[i];
            for (int i = 0; i < MAX_DIMS; i++)
                digit_reg[i] <= digit_next[i];
            dim_reg      <= dim_next;
            nd_reg       <= nd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        carry_reg <= carry_next;
        if (out_load)
        begin
            for (int i = 0; i < NUM_OUT_COORDS; i++)
                out_coord_reg[i] <= out_coord_cur[i];
            out_wrap_reg <= (carry_reg != '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_wrap_reg;

endmodule

// ===== hw/rtl/mrcc_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, 16-bit divisor.
module mrcc_div
    import mrcc_pkg::*;
#(
    parameter int DW = 34
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DW-1:0]     dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [DW-1:0]     quot,
    output logic [SIZE_W-1:0] rem
);

    localparam int CNT_W = $clog2(DW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DW-1:0]     sh_reg, sh_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] dvs_reg, dvs_next;

    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;
    logic              ge;

    // shifted partial remainder stays below twice the divisor
    assign trial = {rem_reg, sh_reg[DW-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            sh_next  = {sh_reg[DW-2:0], ge};
            rem_next = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = sh_reg;
    assign rem  = rem_reg;

endmodule

// ===== dv/testbench.sv =====
// Testbench for the mixed-radix coordinate counter core: directed and random items.
`timescale 1ns / 1ps

module testbench
    import mrcc_pkg::*;
();

    localparam int AMOUNT_W = 32;
    localparam int DIMS_MAX = 4;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MAX_SEND_GAP = 160;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REGISTER = 3'd5;

    typedef struct packed {
        logic                                    wrapped;
        logic [NUM_OUT_COORDS-1:0][COORD_W-1:0]  coord;
    } coord_result_t;

    logic                              clk;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]              cfg_index = '0;
    logic [CFG_DATA_W-1:0]             cfg_data = '0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [AMOUNT_W-1:0]               s_tdata = '0;    // amount
    logic                              s_tuser = 1'b0;  // op
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [NUM_OUT_COORDS*COORD_W-1:0] m_tdata;         // coord0, coord1, coord2, coord3
    logic                              m_tuser;         // wrapped

    // predictor copy of registers and digits
    logic [DIMS_W-1:0]  dims_setting = 3'd1;
    logic [SIZE_W-1:0]  extent_setting [NUM_SIZE_REGS] = '{default: 16'd1};
    logic [COORD_W-1:0] coord_digits [DIMS_MAX] = '{default: 16'd0};

    coord_result_t expected_coords [$];
    int mismatches = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    mixed_radix_coordinate_counter_core #(
        .MAX_DIMS     (DIMS_MAX),
        .AMOUNT_WIDTH (AMOUNT_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int dims_active();
        int nd;
        nd = dims_setting;
        if (nd < 1)
            nd = 1;
        if (nd > DIMS_MAX)
            nd = DIMS_MAX;
        return nd;
    endfunction

    function automatic longint unsigned extent_of_dim(int k);
        longint unsigned e;
        e = 1;
        if (k < NUM_SIZE_REGS)
            e = extent_setting[k];
        if (e == 0)
            e = 1;
        return e;
    endfunction

    // Load decomposes the index; advance adds with carries. Carry out of the top
    // dimension in use is dropped and flagged.
    function automatic coord_result_t step_coordinate(logic op, logic [AMOUNT_W-1:0] amount);
        coord_result_t   r;
        longint unsigned carry;
        longint unsigned ext;
        longint unsigned quo;
        longint unsigned sum;
        int              nd;
        nd = dims_active();
        carry = amount;
        r = '0;
        for (int k = 0; k < nd; k++)
        begin
            ext = extent_of_dim(k);
            if (op == OP_LOAD)
            begin
                coord_digits[k] = COORD_W'(carry % ext);
                carry = carry / ext;
            end
            else if (carry != 0)
            begin
                quo = carry / ext;
                sum = longint'(coord_digits[k]) + carry % ext;
                coord_digits[k] = COORD_W'(sum % ext);
                carry = quo + sum / ext;
            end
        end
        for (int k = 0; k < NUM_OUT_COORDS; k++)
            r.coord[k] = (k < nd) ? coord_digits[k] : '0;
        r.wrapped = (carry != 0);
        return r;
    endfunction

    // Results are checked before the same edge's input is predicted.
    always @(posedge clk)
    begin
        coord_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_coords.size() == 0)
                begin
                    $error("result with no item pending: tdata %h tuser %b", m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_coords.pop_front();
                    for (int k = 0; k < NUM_OUT_COORDS; k++)
                        if (m_tdata[k*COORD_W +: COORD_W] !== want.coord[k])
                        begin
                            $error("coord%0d: expected %0d, got %0d", k, want.coord[k],
                                   m_tdata[k*COORD_W +: COORD_W]);
                            mismatches++;
                        end
                    if (m_tuser !== want.wrapped)
                    begin
                        $error("wrapped: expected %0d, got %0d", want.wrapped, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_DIMS_IN_USE: dims_setting = cfg_data[DIMS_W-1:0];
                    CFG_SIZE_DIM0:   extent_setting[0] = cfg_data[SIZE_W-1:0];
                    CFG_SIZE_DIM1:   extent_setting[1] = cfg_data[SIZE_W-1:0];
                    CFG_SIZE_DIM2:   extent_setting[2] = cfg_data[SIZE_W-1:0];
                    CFG_SIZE_DIM3:   extent_setting[3] = cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_coords.push_back(step_coordinate(s_tuser, s_tdata));
        end
    end

    always @(posedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** mixed_radix_coordinate_counter_core: FAILED **");
            $finish;
        end
    end

    // Leaves tvalid high after acceptance so back-to-back items need no second assignment.
    task automatic send_item(logic op, logic [AMOUNT_W-1:0] amount);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_SEND_GAP)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= amount;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_coords.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_geometry(logic [CFG_DATA_W-1:0] dims_word, logic [SIZE_W-1:0] e0,
                                logic [SIZE_W-1:0] e1, logic [SIZE_W-1:0] e2,
                                logic [SIZE_W-1:0] e3);
        wait_idle();
        write_reg(CFG_DIMS_IN_USE, dims_word);
        write_reg(CFG_SIZE_DIM0, e0);
        write_reg(CFG_SIZE_DIM1, e1);
        write_reg(CFG_SIZE_DIM2, e2);
        write_reg(CFG_SIZE_DIM3, e3);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_extent();
        case ($urandom_range(19))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'd1;
            3, 4:    return SIZE_W'($urandom);
            default: return SIZE_W'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dims();
        logic [CFG_DATA_W-1:0] w;
        w = '0;
        if ($urandom_range(3) == 0)
            w = CFG_DATA_W'($urandom) & ~CFG_DATA_W'(7);   // junk above the field
        if ($urandom_range(3) == 0)
            w[DIMS_W-1:0] = DIMS_W'($urandom_range(0, 7));
        else
            w[DIMS_W-1:0] = DIMS_W'($urandom_range(1, 4));
        return w;
    endfunction

    // Amount shaped by the current geometry so loads and carries land in interesting spots.
    function automatic logic [AMOUNT_W-1:0] pick_amount();
        longint unsigned space;
        longint unsigned lim;
        int              nd;
        nd = dims_active();
        space = 1;
        for (int k = 0; k < nd; k++)
        begin
            space = space * extent_of_dim(k);
            if (space > 64'hFFFF_FFFF)
                space = 64'hFFFF_FFFF;
        end
        lim = space + space / 4;
        if (lim > 64'hFFFF_FFFF)
            lim = 64'hFFFF_FFFF;
        case ($urandom_range(9))
            0, 1, 2, 3: return AMOUNT_W'($urandom_range(0, 3 * extent_of_dim(0)));
            4, 5, 6:    return AMOUNT_W'($urandom_range(0, lim[31:0]));
            7, 8:       return AMOUNT_W'($urandom);
            default:
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return '1;
                    2:       return AMOUNT_W'(space - 1);
                    default: return AMOUNT_W'(space);
                endcase
        endcase
    endfunction

    task automatic test_reset_values();
        // one dimension of extent one: every digit reads zero
        send_item(OP_LOAD, '0);
        send_item(OP_LOAD, '1);
        send_item(OP_ADVANCE, 32'd5);
    endtask

    task automatic test_load_and_advance();
        set_geometry(16'd4, 16'd3, 16'd5, 16'd7, 16'd11);
        send_item(OP_LOAD, 32'd1154);      // last point of the space
        send_item(OP_ADVANCE, 32'd0);
        send_item(OP_ADVANCE, 32'd1);      // full carry chain, wraps to origin
        send_item(OP_LOAD, 32'd1155);      // one past the space
        send_item(OP_ADVANCE, 32'd578);
        send_item(OP_LOAD, '1);
        send_item(OP_ADVANCE, '1);
    endtask

    task automatic test_extent_extremes();
        set_geometry(16'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_LOAD, '1);
        send_item(OP_ADVANCE, '1);
        set_geometry(16'd3, 16'd0, 16'd9, 16'd0, 16'd4);   // zero extent acts as one
        send_item(OP_LOAD, 32'd12345);
        send_item(OP_ADVANCE, 32'd7);
    endtask

    task automatic test_dims_count();
        set_geometry(16'd0, 16'd6, 16'd6, 16'd6, 16'd6);   // zero dims act as one
        send_item(OP_LOAD, 32'd10);
        set_geometry(16'd7, 16'd10, 16'd10, 16'd10, 16'd10); // saturates at four
        send_item(OP_LOAD, 32'd4321);
        // hidden digits are kept while out of use
        set_geometry(16'd2, 16'd10, 16'd10, 16'd10, 16'd10);
        send_item(OP_ADVANCE, 32'd1);
        set_geometry(16'd4, 16'd10, 16'd10, 16'd10, 16'd10);
        send_item(OP_ADVANCE, 32'd0);
    endtask

    task automatic test_shrunk_extent();
        set_geometry(16'd4, 16'd100, 16'd100, 16'd100, 16'd100);
        send_item(OP_LOAD, 32'd98765432);
        // shrink extents 0, 1 and 3: reached digits fold back, unreached ones stay large
        wait_idle();
        write_reg(CFG_SIZE_DIM0, 16'd10);
        write_reg(CFG_SIZE_DIM1, 16'd10);
        write_reg(CFG_SIZE_DIM3, 16'd5);
        write_reg(CFG_NO_REGISTER, 16'hFFFF);              // no register there
        cfg_we <= 1'b0;
        send_item(OP_ADVANCE, 32'd1);
        send_item(OP_ADVANCE, 32'd0);
    endtask

    task automatic test_random_traffic(int send_pct, int stall_pc, int rounds, int per_round);
        send_idle_pct = send_pct;
        stall_pct     = stall_pc;
        for (int r = 0; r < rounds; r++)
        begin
            set_geometry(pick_dims(), pick_extent(), pick_extent(), pick_extent(),
                         pick_extent());
            // a load then mostly advances from it
            send_item(OP_LOAD, pick_amount());
            for (int i = 1; i < per_round; i++)
                send_item(($urandom_range(3) == 0) ? OP_LOAD : OP_ADVANCE, pick_amount());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_load_and_advance();
        test_extent_extremes();
        test_dims_count();
        test_shrunk_extent();
        test_random_traffic(0, 0, 8, 60);
        test_random_traffic(75, 0, 8, 60);
        test_random_traffic(0, 75, 8, 60);
        test_random_traffic(19, 19, 8, 60);
        wait_idle();
        repeat (400) @(posedge clk);
        if (mismatches == 0)
            $display("** mixed_radix_coordinate_counter_core: PASSED **");
        else
            $display("** mixed_radix_coordinate_counter_core: FAILED **");
        $finish;
    end

endmodule
